@@ sv/cbt_pkg.sv @@
// ----------------------------------------------------------------------------
// cbt_pkg: shared types and constants of the CSV byte tokenizer
// Widths, byte codes, result and status codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

  // sizing
  localparam int HOLD_DEPTH  = 16;
  localparam int MAX_FIELDS  = 1024;
  localparam int HOLD_IDX_W  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int HOLD_CNT_W  = $clog2(HOLD_DEPTH + 1);
  localparam int FIELD_IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int FIELD_CNT_W = $clog2(MAX_FIELDS + 1);
  localparam int ROW_W       = 32;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // byte codes
  localparam logic [BYTE_W-1:0] CH_LF        = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'd13;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'd44;
  localparam logic [BYTE_W-1:0] QUOTE_RESET  = 8'd34;

  typedef enum logic [1:0] {
    RK_CONTENT   = 2'd0,
    RK_FIELD_END = 2'd1,
    RK_ROW_END   = 2'd2
  } rkind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OPEN_QUOTE = 2'd1,
    ST_HOLD_OVF   = 2'd2
  } status_t;

  // quote tracking: outside, inside, inside with one quote just seen
  typedef enum logic [1:0] {
    QM_OUT   = 2'd0,
    QM_IN    = 2'd1,
    QM_QSEEN = 2'd2
  } qmode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIMITER = 2'd0,
    CFG_QUOTE     = 2'd1,
    CFG_TRIM      = 2'd2,
    CFG_HEADER    = 2'd3
  } cfg_reg_t;

  // what an accepted item calls for
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_HOLD,
    ACT_CONTENT,
    ACT_FLUSH_C,
    ACT_FLUSH_O,
    ACT_FIELD,
    ACT_ROW,
    ACT_EOS_ROW,
    ACT_EOS_NONE
  } act_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CONTENT,
    EM_HOLD,
    EM_FIELD,
    EM_ROW
  } emit_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH_C,
    S_FLUSH_O,
    S_CONTENT,
    S_ROW
  } state_t;

  typedef struct packed {
    logic    accept;
    emit_t   emit;
    logic    last;
    logic    field_inc;
    logic    hold_clear;
    logic    ovf_done;
    status_t hold_status;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;
    logic flush_last;
    logic slot_free;
  } dp_stat_t;

  function automatic logic is_space(logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

`default_nettype wire

@@ sv/cbt_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbt_ctrl: sequencing controller of the CSV byte tokenizer
// Takes items, and steps through whitespace flushes and row ends one result
// per cycle while the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_ctrl
  import cbt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   take;

  assign take = (state_r == S_IDLE) && in_valid && stat.slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (stat.act)
            ACT_FLUSH_C:          state_nxt = stat.flush_last ? S_CONTENT : S_FLUSH_C;
            ACT_FLUSH_O:          state_nxt = stat.flush_last ? S_IDLE : S_FLUSH_O;
            ACT_ROW, ACT_EOS_ROW: state_nxt = S_ROW;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_FLUSH_C: if (stat.slot_free && stat.flush_last) state_nxt = S_CONTENT;
      S_FLUSH_O: if (stat.slot_free && stat.flush_last) state_nxt = S_IDLE;
      S_CONTENT: if (stat.slot_free) state_nxt = S_IDLE;
      S_ROW:     if (stat.slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready        = (state_r == S_IDLE) && stat.slot_free;
    cmd             = '0;
    cmd.emit        = EM_NONE;
    cmd.hold_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.accept = 1'b1;
          unique case (stat.act)
            ACT_CONTENT: begin
              cmd.emit = EM_CONTENT;
              cmd.last = 1'b1;
            end
            ACT_FIELD: begin
              cmd.emit      = EM_FIELD;
              cmd.last      = 1'b1;
              cmd.field_inc = 1'b1;
            end
            ACT_ROW, ACT_EOS_ROW: begin
              cmd.emit = EM_FIELD;
            end
            ACT_FLUSH_C: begin
              cmd.emit       = EM_HOLD;
              cmd.hold_clear = stat.flush_last;
            end
            ACT_FLUSH_O: begin
              cmd.emit        = EM_HOLD;
              cmd.hold_status = ST_HOLD_OVF;
              cmd.last        = stat.flush_last;
              cmd.ovf_done    = stat.flush_last;
            end
            default: cmd.emit = EM_NONE;
          endcase
        end
      end
      S_FLUSH_C: begin
        if (stat.slot_free) begin
          cmd.emit       = EM_HOLD;
          cmd.hold_clear = stat.flush_last;
        end
      end
      S_FLUSH_O: begin
        if (stat.slot_free) begin
          cmd.emit        = EM_HOLD;
          cmd.hold_status = ST_HOLD_OVF;
          cmd.last        = stat.flush_last;
          cmd.ovf_done    = stat.flush_last;
        end
      end
      S_CONTENT: begin
        if (stat.slot_free) begin
          cmd.emit = EM_CONTENT;
          cmd.last = 1'b1;
        end
      end
      S_ROW: begin
        if (stat.slot_free) begin
          cmd.emit = EM_ROW;
          cmd.last = 1'b1;
        end
      end
      default: cmd.emit = EM_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/cbt_datapath.sv @@
// ----------------------------------------------------------------------------
// cbt_datapath: byte classification, tokenizer state and result register
// Holds configuration, row/field/quote state, the whitespace hold, the
// statistics and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_datapath
  import cbt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_kind,
  input  wire logic [BYTE_W-1:0]      in_data_byte,
  input  wire logic                   out_ready,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat,
  output logic                        out_valid,
  output logic [1:0]                  out_result_kind,
  output logic [BYTE_W-1:0]           out_out_byte,
  output logic [FIELD_IDX_W-1:0]      out_field_index,
  output logic [ROW_W-1:0]            out_row_number,
  output logic                        out_is_header,
  output logic [FIELD_CNT_W-1:0]      out_field_count,
  output logic [FIELD_CNT_W-1:0]      out_min_fields,
  output logic [FIELD_CNT_W-1:0]      out_max_fields,
  output logic [1:0]                  out_status,
  output logic                        out_last
);

  // configuration
  logic [BYTE_W-1:0] delim_r, quote_r;
  logic              trim_r, hdr_en_r;

  // tokenizer state
  logic                   in_row_r, in_row_nxt;
  qmode_t                 qmode_r, qmode_nxt;
  logic                   cseen_r, cseen_nxt;
  logic [HOLD_CNT_W-1:0]  hcnt_r, hcnt_nxt;
  logic [FIELD_IDX_W-1:0] fidx_r, fidx_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [FIELD_CNT_W-1:0] few_r, few_nxt, most_r, most_nxt;
  logic [HOLD_IDX_W-1:0]  fptr_r, fptr_nxt;
  logic                   eos_r, st_r;
  logic [BYTE_W-1:0]      pend_r;
  logic [BYTE_W-1:0]      hold_r [HOLD_DEPTH];

  // hold write port
  logic                  hold_we;
  logic [HOLD_IDX_W-1:0] hold_waddr;
  logic [BYTE_W-1:0]     hold_wdata;

  // output register
  logic                   oval_r, oval_nxt;
  rkind_t                 okind_r, okind_nxt;
  logic [BYTE_W-1:0]      obyte_r, obyte_nxt;
  logic [FIELD_IDX_W-1:0] ofidx_r, ofidx_nxt;
  logic [ROW_W-1:0]       orow_r, orow_nxt;
  logic                   ohdr_r, ohdr_nxt;
  logic [FIELD_CNT_W-1:0] ocnt_r, ocnt_nxt, omin_r, omin_nxt, omax_r, omax_nxt;
  status_t                ost_r, ost_nxt;
  logic                   olast_r, olast_nxt;

  // classification
  logic [BYTE_W-1:0]      b;
  logic                   is_q, is_nl, is_del, is_sp, skip;
  qmode_t                 qm_eff, qm2, qm_new;
  logic [HOLD_CNT_W-1:0]  hc_eff;
  logic                   cs_eff, is_content, set_cseen, st_now;
  logic [FIELD_IDX_W-1:0] fi_eff, fi_cur;
  logic [ROW_W-1:0]       row_inc, row_eff, row_cur;
  logic                   hdr_cur;
  logic [FIELD_CNT_W-1:0] row_cnt;
  act_t                   act;

  assign b       = in_data_byte;
  assign is_q    = (b == quote_r);
  assign is_nl   = (b == CH_CR) || (b == CH_LF);
  assign is_del  = (b == delim_r);
  assign is_sp   = is_space(b);
  assign skip    = !in_row_r && !is_q && is_nl;
  assign st_now  = in_kind && (qmode_r == QM_IN);
  assign row_inc = (row_r != {ROW_W{1'b1}}) ? row_r + 1'b1 : row_r;
  assign qm_eff  = in_row_r ? qmode_r : QM_OUT;
  assign hc_eff  = in_row_r ? hcnt_r : '0;
  assign cs_eff  = in_row_r && cseen_r;
  assign fi_eff  = in_row_r ? fidx_r : '0;
  assign row_eff = in_row_r ? row_r : row_inc;

  // values seen by a result produced in this cycle
  assign fi_cur  = cmd.accept ? fi_eff : fidx_r;
  assign row_cur = cmd.accept ? row_eff : row_r;
  assign hdr_cur = hdr_en_r && (row_cur == ROW_W'(1));
  assign row_cnt = FIELD_CNT_W'(fidx_r) + FIELD_CNT_W'(1);

  // decode of the offered item
  always_comb begin
    act        = ACT_NONE;
    qm2        = qm_eff;
    qm_new     = qm_eff;
    is_content = 1'b0;
    set_cseen  = 1'b0;
    if (in_kind) begin
      act = in_row_r ? ACT_EOS_ROW : ACT_EOS_NONE;
    end else if (!skip) begin
      if ((qm_eff == QM_QSEEN) && is_q) begin
        // doubled quote: one literal quote
        is_content = 1'b1;
        qm_new     = QM_IN;
      end else begin
        qm2    = (qm_eff == QM_QSEEN) ? QM_OUT : qm_eff;
        qm_new = qm2;
        priority if (qm2 == QM_IN) begin
          if (is_q) qm_new = QM_QSEEN;
          else      is_content = 1'b1;
        end else if (is_q) begin
          qm_new = QM_IN;
        end else if (is_nl) begin
          act = ACT_ROW;
        end else if (is_del) begin
          act = ACT_FIELD;
        end else begin
          is_content = 1'b1;
        end
      end
      if (is_content) begin
        priority if (!trim_r) begin
          act = ACT_CONTENT;
        end else if (is_sp) begin
          if (!cs_eff)                             act = ACT_NONE;
          else if (hc_eff >= HOLD_CNT_W'(HOLD_DEPTH)) act = ACT_FLUSH_O;
          else                                     act = ACT_HOLD;
        end else begin
          set_cseen = 1'b1;
          act       = (hc_eff != '0) ? ACT_FLUSH_C : ACT_CONTENT;
        end
      end
    end
  end

  always_comb begin
    stat.act        = act;
    stat.slot_free  = !oval_r || out_ready;
    stat.flush_last = ((HOLD_CNT_W'(fptr_r) + HOLD_CNT_W'(1)) == hcnt_r);
  end

  // state update
  always_comb begin
    in_row_nxt = in_row_r;
    qmode_nxt  = qmode_r;
    cseen_nxt  = cseen_r;
    hcnt_nxt   = hcnt_r;
    fidx_nxt   = fidx_r;
    row_nxt    = row_r;
    few_nxt    = few_r;
    most_nxt   = most_r;
    fptr_nxt   = fptr_r;
    hold_we    = 1'b0;
    hold_waddr = hc_eff[HOLD_IDX_W-1:0];
    hold_wdata = b;

    if (cmd.accept) begin
      if (in_kind) begin
        if (!in_row_r) begin
          // end of stream between rows: just restart the stream
          qmode_nxt = QM_OUT;
          cseen_nxt = 1'b0;
          hcnt_nxt  = '0;
          fidx_nxt  = '0;
          row_nxt   = '0;
        end
      end else if (!skip) begin
        in_row_nxt = 1'b1;
        row_nxt    = row_eff;
        fidx_nxt   = fi_eff;
        qmode_nxt  = qm_new;
        cseen_nxt  = cs_eff || set_cseen;
        hcnt_nxt   = hc_eff;
        if (act == ACT_HOLD) begin
          hold_we  = 1'b1;
          hcnt_nxt = hc_eff + 1'b1;
        end
      end
    end

    unique case (cmd.emit)
      EM_FIELD: begin
        hcnt_nxt  = '0;
        cseen_nxt = 1'b0;
        if (cmd.field_inc && (fi_cur != FIELD_IDX_W'(MAX_FIELDS - 1))) begin
          fidx_nxt = fi_cur + 1'b1;
        end
      end
      EM_ROW: begin
        in_row_nxt = 1'b0;
        qmode_nxt  = QM_OUT;
        if (!hdr_cur) begin
          if (row_cnt < few_r)  few_nxt  = row_cnt;
          if (row_cnt > most_r) most_nxt = row_cnt;
        end
        if (eos_r) begin
          cseen_nxt = 1'b0;
          hcnt_nxt  = '0;
          fidx_nxt  = '0;
          row_nxt   = '0;
        end
      end
      EM_HOLD: begin
        fptr_nxt = stat.flush_last ? '0 : fptr_r + 1'b1;
        if (cmd.hold_clear) hcnt_nxt = '0;
        if (cmd.ovf_done) begin
          // the overflowing byte becomes the only held byte
          hold_we    = 1'b1;
          hold_waddr = '0;
          hold_wdata = cmd.accept ? b : pend_r;
          hcnt_nxt   = HOLD_CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register load
  always_comb begin
    oval_nxt  = oval_r && !out_ready;
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    ofidx_nxt = ofidx_r;
    orow_nxt  = orow_r;
    ohdr_nxt  = ohdr_r;
    ocnt_nxt  = ocnt_r;
    omin_nxt  = omin_r;
    omax_nxt  = omax_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;
    if (cmd.emit != EM_NONE) begin
      oval_nxt  = 1'b1;
      okind_nxt = RK_CONTENT;
      obyte_nxt = '0;
      ofidx_nxt = fi_cur;
      orow_nxt  = row_cur;
      ohdr_nxt  = hdr_cur;
      ocnt_nxt  = '0;
      omin_nxt  = few_r;
      omax_nxt  = most_r;
      ost_nxt   = ST_OK;
      olast_nxt = cmd.last;
      unique case (cmd.emit)
        EM_CONTENT: obyte_nxt = cmd.accept ? b : pend_r;
        EM_HOLD: begin
          obyte_nxt = hold_r[fptr_r];
          ost_nxt   = cmd.hold_status;
        end
        EM_FIELD: begin
          okind_nxt = RK_FIELD_END;
          ost_nxt   = st_now ? ST_OPEN_QUOTE : ST_OK;
        end
        EM_ROW: begin
          okind_nxt = RK_ROW_END;
          ocnt_nxt  = row_cnt;
          omin_nxt  = few_nxt;
          omax_nxt  = most_nxt;
          ost_nxt   = st_r ? ST_OPEN_QUOTE : ST_OK;
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r  <= DELIM_RESET;
      quote_r  <= QUOTE_RESET;
      trim_r   <= 1'b0;
      hdr_en_r <= 1'b0;
      in_row_r <= 1'b0;
      qmode_r  <= QM_OUT;
      cseen_r  <= 1'b0;
      hcnt_r   <= '0;
      fidx_r   <= '0;
      row_r    <= '0;
      few_r    <= FIELD_CNT_W'(MAX_FIELDS);
      most_r   <= '0;
      fptr_r   <= '0;
      oval_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_DELIMITER: delim_r  <= cfg_data;
          CFG_QUOTE:     quote_r  <= cfg_data;
          CFG_TRIM:      trim_r   <= cfg_data[0];
          CFG_HEADER:    hdr_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      in_row_r <= in_row_nxt;
      qmode_r  <= qmode_nxt;
      cseen_r  <= cseen_nxt;
      hcnt_r   <= hcnt_nxt;
      fidx_r   <= fidx_nxt;
      row_r    <= row_nxt;
      few_r    <= few_nxt;
      most_r   <= most_nxt;
      fptr_r   <= fptr_nxt;
      oval_r   <= oval_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_r <= b;
      eos_r  <= in_kind;
      st_r   <= st_now;
    end
    if (hold_we) hold_r[hold_waddr] <= hold_wdata;
    okind_r <= okind_nxt;
    obyte_r <= obyte_nxt;
    ofidx_r <= ofidx_nxt;
    orow_r  <= orow_nxt;
    ohdr_r  <= ohdr_nxt;
    ocnt_r  <= ocnt_nxt;
    omin_r  <= omin_nxt;
    omax_r  <= omax_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = oval_r;
  assign out_result_kind = okind_r;
  assign out_out_byte    = obyte_r;
  assign out_field_index = ofidx_r;
  assign out_row_number  = orow_r;
  assign out_is_header   = ohdr_r;
  assign out_field_count = ocnt_r;
  assign out_min_fields  = omin_r;
  assign out_max_fields  = omax_r;
  assign out_status      = ost_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

@@ sv/csv_byte_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// csv_byte_tokenizer_unit: streaming CSV tokenizer, one byte per item
// Turns CSV text into content bytes, end-of-field and end-of-row results.
// ----------------------------------------------------------------------------
// A text item that yields at most one result (plain content byte, delimiter,
// quote, skipped line ending, held whitespace) needs no sequencing, so bytes
// stream at one per cycle while the result side keeps up. A line ending that
// closes a row, and end of stream inside a row, yield end of field, then end
// of row. A non-whitespace byte that releases N held whitespace bytes yields
// those N bytes, then itself, and a whitespace byte that overflows the hold
// yields HOLD_DEPTH held bytes; the controller steps the hold read pointer,
// one result per cycle while the output register is free. Results leave
// through an output register, so the next item is taken in the same cycle
// the previous result is taken. Configuration writes are registered and
// must only be issued while no item is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_byte_tokenizer_unit
  import cbt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration: delimiter, quote byte, trim enable, header enable
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_kind,
  input  wire logic [BYTE_W-1:0]      in_data_byte,
  // result items
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_result_kind,
  output logic [BYTE_W-1:0]           out_out_byte,
  output logic [FIELD_IDX_W-1:0]      out_field_index,
  output logic [ROW_W-1:0]            out_row_number,
  output logic                        out_is_header,
  output logic [FIELD_CNT_W-1:0]      out_field_count,
  output logic [FIELD_CNT_W-1:0]      out_min_fields,
  output logic [FIELD_CNT_W-1:0]      out_max_fields,
  output logic [1:0]                  out_status,
  output logic                        out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: accepts items, sequences multi-result items
  cbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: classification, state, hold, stats, output register
  cbt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_out_byte    (out_out_byte),
    .out_field_index (out_field_index),
    .out_row_number  (out_row_number),
    .out_is_header   (out_is_header),
    .out_field_count (out_field_count),
    .out_min_fields  (out_min_fields),
    .out_max_fields  (out_max_fields),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

@@ sv/cbt_checker.sv @@
// ----------------------------------------------------------------------------
// cbt_checker: port-level checks of the CSV byte tokenizer
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_checker
  import cbt_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [1:0]             out_result_kind,
  input wire logic [BYTE_W-1:0]      out_out_byte,
  input wire logic [FIELD_CNT_W-1:0] out_field_count,
  input wire logic [FIELD_CNT_W-1:0] out_min_fields,
  input wire logic [FIELD_CNT_W-1:0] out_max_fields,
  input wire logic                   out_is_header,
  input wire logic                   out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_out_byte) && $stable(out_field_count) && $stable(out_last))
    else $error("result changed while stalled");

  // a row end is always the final result of its item
  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_ROW_END) |-> out_last)
    else $error("row end not marked last");

  // only row ends carry a field count
  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != RK_ROW_END) |-> (out_field_count == '0))
    else $error("field count on non-row result");

  // a data row's count lies within the running statistics
  a_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_ROW_END) && !out_is_header
      |-> (out_min_fields <= out_field_count) && (out_max_fields >= out_field_count))
    else $error("row count outside min/max");

endmodule

bind csv_byte_tokenizer_unit cbt_checker u_cbt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_out_byte    (out_out_byte),
  .out_field_count (out_field_count),
  .out_min_fields  (out_min_fields),
  .out_max_fields  (out_max_fields),
  .out_is_header   (out_is_header),
  .out_last        (out_last)
);

`default_nettype wire
